// ===== rtl/ffpsa_pkg.sv =====
// Shared types, widths and status codes for the first-fit pair slot allocator.
`default_nettype none

package ffpsa_pkg;

  // Fixed field widths of the request and result
  localparam int PARTY_W  = 5;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 2;
  localparam int USED_W   = 7;

  // Default sizing
  localparam int SLOTS_DEF   = 64;
  localparam int PARTIES_DEF = 32;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SAME = 2'd2;

  typedef struct packed {
    logic [PARTY_W-1:0] party_a;
    logic [PARTY_W-1:0] party_b;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;
    logic [USED_W-1:0]   slots_used;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic rd;        // request accepted: capture parties, read both rows
    logic look;      // evaluate lookup, update slot count
    logic wr_a;      // write back row of party a
    logic wr_b;      // write back row of party b
    logic load_out;  // move result into output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic found;     // a common free slot exists for a valid pair
    logic out_free;  // output register can take a result this cycle
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/ffpsa_ctrl.sv =====
// Sequencing state machine for the first-fit pair slot allocator.
`default_nettype none

module ffpsa_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire ffpsa_pkg::stat_t stat,
  output ffpsa_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_WRA  = 3'd2;
  localparam logic [2:0] S_WRB  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_ready     = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.rd     = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look   = 1'b1;
        state_next = stat.found ? S_WRA : S_DONE;
      end
      S_WRA: begin
        cmd.wr_a   = 1'b1;
        state_next = S_WRB;
      end
      S_WRB: begin
        cmd.wr_b   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold here while the previous result is still unclaimed
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/ffpsa_dp.sv =====
// Datapath: busy bitmap memory, first-fit search, slot count and output register.
`default_nettype none

module ffpsa_dp #(
  parameter int SLOTS   = ffpsa_pkg::SLOTS_DEF,
  parameter int PARTIES = ffpsa_pkg::PARTIES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ffpsa_pkg::in_t  in_data,
  input  wire ffpsa_pkg::cmd_t cmd,
  output ffpsa_pkg::stat_t     stat,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output ffpsa_pkg::out_t      out_data
);

  localparam int ROWS    = (PARTIES < (1 << ffpsa_pkg::PARTY_W)) ?
                           PARTIES : (1 << ffpsa_pkg::PARTY_W);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int SIDX_W  = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int CMP_W   = ffpsa_pkg::PARTY_W + 2;
  localparam logic [CMP_W-1:0] PARTY_LIM = CMP_W'(PARTIES);

  // Busy bitmap rows with per-row valid bits
  logic [SLOTS-1:0] mem [ROWS];
  logic [ROWS-1:0]  row_vld;

  logic [ffpsa_pkg::PARTY_W-1:0] pa;
  logic [ffpsa_pkg::PARTY_W-1:0] pb;
  logic [SLOTS-1:0]              rd_a;
  logic [SLOTS-1:0]              rd_b;
  logic                          va;
  logic                          vb;
  logic [CNT_W-1:0]              used;

  logic [SLOTS-1:0]  map_a;
  logic [SLOTS-1:0]  map_b;
  logic [SLOTS-1:0]  free;
  logic [SLOTS-1:0]  pick;
  logic [SIDX_W-1:0] idx;
  logic [CNT_W-1:0]  idx_p1;
  logic              same;
  logic              bad;
  logic              found;
  logic [ROW_W-1:0]  wr_addr;
  logic [SLOTS-1:0]  wr_data;
  logic              wr_en;

  // Capture parties on accept
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      pa <= in_data.party_a;
      pb <= in_data.party_b;
    end
  end

  // Memory: two registered reads, one write
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_a <= mem[in_data.party_a[ROW_W-1:0]];
      rd_b <= mem[in_data.party_b[ROW_W-1:0]];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Row valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      va      <= 1'b0;
      vb      <= 1'b0;
    end else begin
      if (cmd.rd) begin
        va <= row_vld[in_data.party_a[ROW_W-1:0]];
        vb <= row_vld[in_data.party_b[ROW_W-1:0]];
      end
      if (wr_en) begin
        row_vld[wr_addr] <= 1'b1;
      end
    end
  end

  // First-fit search over the two bitmaps
  always_comb begin
    map_a = va ? rd_a : '0;
    map_b = vb ? rd_b : '0;
    free  = ~(map_a | map_b);
    pick  = free & (~free + SLOTS'(1));
    idx   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (pick[i]) begin
        idx = idx | SIDX_W'(i);
      end
    end
    idx_p1 = CNT_W'(idx) + CNT_W'(1);
    same   = (pa == pb);
    bad    = ({2'b00, pa} >= PARTY_LIM) || ({2'b00, pb} >= PARTY_LIM);
    found  = !same && !bad && (|free);
  end

  // Write-back: one row per cycle
  always_comb begin
    wr_en   = cmd.wr_a || cmd.wr_b;
    wr_addr = cmd.wr_a ? pa[ROW_W-1:0] : pb[ROW_W-1:0];
    wr_data = cmd.wr_a ? (map_a | pick) : (map_b | pick);
  end

  // Highest assigned slot plus one
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.look && found && (idx_p1 > used)) begin
      used <= idx_p1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.slot       <= found ? ffpsa_pkg::SLOT_W'(idx) : '0;
      out_data.status     <= same  ? ffpsa_pkg::ST_SAME :
                             found ? ffpsa_pkg::ST_OK : ffpsa_pkg::ST_FULL;
      out_data.slots_used <= ffpsa_pkg::USED_W'(used);
    end
  end

  always_comb begin
    stat.found    = found;
    stat.out_free = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

// ===== rtl/first_fit_pair_slot_allocator.sv =====
// First-fit pair slot allocator: keeps a busy bitmap per party and hands out
// the lowest slot that is free for both parties of each request.
//
// Input channel in_valid/in_ready/in_data carries a pair of party indices.
// Output channel out_valid/out_ready/out_data carries one result per request:
// the slot, a status (assigned, no common free slot or a party out of range,
// same party twice) and the number of slots used so far.
// A request passes through accept, lookup, write of row a, write of row b and
// result load when a slot is assigned, and through accept, lookup and result
// load when it fails; the result shows on out_data the cycle after the load.
// The single write port of the bitmap memory is why rows a and b are written
// in separate steps. A new request is taken only after the last one's result
// is loaded; in_ready is high only between requests.
// The output register holds a finished result while the next request is
// accepted; if the receiver stalls, the block waits at the result load.
// Reset clears the slot count and every row's valid bit at once, so all
// slots read as free right after reset with no clearing pass.
`default_nettype none

module first_fit_pair_slot_allocator #(
  parameter int SLOTS   = ffpsa_pkg::SLOTS_DEF,
  parameter int PARTIES = ffpsa_pkg::PARTIES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire ffpsa_pkg::in_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output ffpsa_pkg::out_t     out_data
);

  ffpsa_pkg::cmd_t  cmd;
  ffpsa_pkg::stat_t stat;

  ffpsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffpsa_dp #(
    .SLOTS   (SLOTS),
    .PARTIES (PARTIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // An assigned slot always lies below the reported slot count
  a_slot_below_used: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ffpsa_pkg::ST_OK) |->
      ({1'b0, out_data.slot} < out_data.slots_used))
    else $error("assigned slot not below slots_used");

  // Failed requests report slot zero
  a_fail_slot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != ffpsa_pkg::ST_OK) |-> (out_data.slot == '0))
    else $error("failed request with nonzero slot");

  // Controller issues at most one command per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("overlapping datapath commands");

  // A row write is always followed by the second row write
  a_write_pair: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_a |=> cmd.wr_b)
    else $error("row b write did not follow row a write");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/first_fit_pair_slot_allocator_tb.sv =====
// Self-checking testbench for the first-fit pair slot allocator.
`default_nettype none

module first_fit_pair_slot_allocator_tb;

  localparam int SLOTS          = ffpsa_pkg::SLOTS_DEF;
  localparam int PARTIES        = ffpsa_pkg::PARTIES_DEF;
  localparam int HOT_N          = 3;     // parties in one hot group
  localparam int DRAIN_CYCLES   = 12;    // settle time after the last result is taken
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all

  logic            clk = 1'b0;
  logic            rst;
  logic            in_valid;
  logic            in_ready;
  ffpsa_pkg::in_t  in_data;
  logic            out_valid;
  logic            out_ready;
  ffpsa_pkg::out_t out_data;

  // Idle mix, in percent of cycles
  int send_idle_pct;
  int recv_idle_pct;

  // Predicted block state
  logic [SLOTS-1:0]             busy_rows [PARTIES];
  logic [ffpsa_pkg::USED_W-1:0] used_slot_count;
  ffpsa_pkg::out_t              pending_results[$];

  // Run statistics
  int error_count    = 0;
  int request_count  = 0;
  int assigned_count = 0;
  int full_count     = 0;
  int same_count     = 0;
  int peak_used      = 0;
  int stall_cycles   = 0;

  first_fit_pair_slot_allocator #(
    .SLOTS   (SLOTS),
    .PARTIES (PARTIES)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Lowest slot free for both parties; updates the predicted bitmaps
  function automatic ffpsa_pkg::out_t predict_alloc(input ffpsa_pkg::in_t req);
    ffpsa_pkg::out_t  res;
    logic [SLOTS-1:0] open_slots;
    int               idx;
    res = '0;
    if (req.party_a == req.party_b) begin
      res.status = ffpsa_pkg::ST_SAME;
    end else if (req.party_a >= PARTIES || req.party_b >= PARTIES) begin
      res.status = ffpsa_pkg::ST_FULL;
    end else begin
      open_slots = ~(busy_rows[req.party_a] | busy_rows[req.party_b]);
      if (open_slots == '0) begin
        res.status = ffpsa_pkg::ST_FULL;
      end else begin
        idx = 0;
        while (!open_slots[idx]) idx++;
        busy_rows[req.party_a][idx] = 1'b1;
        busy_rows[req.party_b][idx] = 1'b1;
        res.status = ffpsa_pkg::ST_OK;
        res.slot   = idx[ffpsa_pkg::SLOT_W-1:0];
        if (idx + 1 > int'(used_slot_count))
          used_slot_count = ffpsa_pkg::USED_W'(idx + 1);
      end
    end
    res.slots_used = used_slot_count;
    return res;
  endfunction

  // Mostly pairs from a small hot group so rows fill up, plus same-party and uniform pairs
  function automatic ffpsa_pkg::in_t pick_random_pair(
      input logic [ffpsa_pkg::PARTY_W-1:0] hot_base);
    ffpsa_pkg::in_t req;
    int             roll;
    int             first;
    int             second;
    roll = $urandom_range(99);
    if (roll < 10) begin
      req.party_a = ffpsa_pkg::PARTY_W'($urandom_range(PARTIES - 1));
      req.party_b = req.party_a;
    end else if (roll < 70) begin
      first       = $urandom_range(HOT_N - 1);
      second      = (first + 1 + $urandom_range(HOT_N - 2)) % HOT_N;
      req.party_a = hot_base + ffpsa_pkg::PARTY_W'(first);
      req.party_b = hot_base + ffpsa_pkg::PARTY_W'(second);
    end else begin
      req.party_a = ffpsa_pkg::PARTY_W'($urandom_range(PARTIES - 1));
      req.party_b = ffpsa_pkg::PARTY_W'($urandom_range(PARTIES - 1));
    end
    return req;
  endfunction

  // Offer one request, with random sender gaps first; returns at the accepting edge
  task automatic send_request(input ffpsa_pkg::in_t req);
    ffpsa_pkg::in_t junk;
    while ($urandom_range(99) < send_idle_pct) begin
      junk.party_a = ffpsa_pkg::PARTY_W'($urandom_range(PARTIES - 1));
      junk.party_b = ffpsa_pkg::PARTY_W'($urandom_range(PARTIES - 1));
      in_valid <= 1'b0;
      in_data  <= junk;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_pair(input int a, input int b);
    ffpsa_pkg::in_t req;
    req.party_a = ffpsa_pkg::PARTY_W'(a);
    req.party_b = ffpsa_pkg::PARTY_W'(b);
    send_request(req);
  endtask

  // Field extremes and alternating bit patterns
  task automatic test_field_extremes();
    send_pair(0, 31);
    send_pair(31, 0);
    send_pair(0, 1);
    send_pair(31, 30);
    send_pair(21, 10);
    send_pair(10, 21);
  endtask

  // Same party twice must not touch any row or the slot count
  task automatic test_same_party();
    send_pair(0, 0);
    send_pair(31, 31);
    send_pair(21, 21);
    send_pair(0, 31);
  endtask

  // Chains of overlapping pairs that leave holes below the top slot
  task automatic test_first_fit_gaps();
    send_pair(2, 3);
    send_pair(3, 4);
    send_pair(2, 4);
    send_pair(5, 6);
    send_pair(2, 5);
    send_pair(7, 8);
    send_pair(3, 7);
    send_pair(8, 5);
    send_pair(6, 9);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int count,
                                     input logic [ffpsa_pkg::PARTY_W-1:0] hot_base);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_request(pick_random_pair(hot_base));
  endtask

  // Receiver back-pressure
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else     out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Predict on every accepted request, check every accepted result
  always @(posedge clk) begin : check_results
    ffpsa_pkg::out_t want;
    if (rst) begin
      for (int p = 0; p < PARTIES; p++) busy_rows[p] = '0;
      used_slot_count = '0;
      pending_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        want = predict_alloc(in_data);
        pending_results.push_back(want);
        request_count++;
        if (want.status == ffpsa_pkg::ST_OK)        assigned_count++;
        else if (want.status == ffpsa_pkg::ST_FULL) full_count++;
        else                                        same_count++;
        if (int'(want.slots_used) > peak_used) peak_used = int'(want.slots_used);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          if (error_count < 10)
            $display("ERROR: unrequested result slot=%0d status=%0d slots_used=%0d",
                     out_data.slot, out_data.status, out_data.slots_used);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.slot !== want.slot || out_data.status !== want.status ||
              out_data.slots_used !== want.slots_used) begin
            if (error_count < 10)
              $display("ERROR: expected slot=%0d status=%0d slots_used=%0d, got %0d/%0d/%0d",
                       want.slot, want.status, want.slots_used,
                       out_data.slot, out_data.status, out_data.slots_used);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    send_idle_pct = 8;
    recv_idle_pct = 69;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_same_party();
    test_first_fit_gaps();
    test_random_traffic(8, 69, 185, 5'd3);
    test_random_traffic(69, 8, 185, 5'd17);
    test_random_traffic(0, 0, 180, 5'd29);
    in_valid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests under three idle mixes: %0d assigned,",
             request_count, assigned_count);
    $display("%0d with no common slot, %0d same party; peak slot count %0d of %0d",
             full_count, same_count, peak_used, SLOTS);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/ffpsa_pkg.sv
rtl/ffpsa_ctrl.sv
rtl/ffpsa_dp.sv
rtl/first_fit_pair_slot_allocator.sv
tb/sv/first_fit_pair_slot_allocator_tb.sv
